// ----- rtl/core/svmie_pkg.sv -----
// package: widths, codes, pool index wrap table and field conversions for the stack machine
`default_nettype none

package svmie_pkg;

	localparam int STACK_DEPTH = 512;
	localparam int POOL_DEPTH = 256;
	localparam int WORD_BITS = 32;

	localparam int FIELD_BITS = 32;
	localparam int ACTION_BITS = 3;
	localparam int STATUS_BITS = 3;
	localparam int PIDX_IN_BITS = 8;
	localparam int POOL_IN_DEPTH = 1 << PIDX_IN_BITS;

	localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);
	localparam int SADDR_BITS = $clog2(STACK_DEPTH);
	localparam int PADDR_BITS = $clog2(POOL_DEPTH);

	localparam int MUL_DIGIT = 8;
	localparam int MUL_STEPS = (WORD_BITS + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int STEP_BITS = $clog2(WORD_BITS + 1);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_BITS-1:0] count_t;
	typedef logic [SADDR_BITS-1:0] saddr_t;
	typedef logic [PADDR_BITS-1:0] paddr_t;
	typedef logic [STEP_BITS-1:0] step_t;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_HALT   = 3'd0,
		ACT_PUSH   = 3'd1,
		ACT_ADD    = 3'd2,
		ACT_SUB    = 3'd3,
		ACT_MUL    = 3'd4,
		ACT_DIV    = 3'd5,
		ACT_STORE  = 3'd6,
		ACT_POOLWR = 3'd7
	} action_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 3'd0,
		ST_HALT  = 3'd1,
		ST_OVER  = 3'd2,
		ST_UNDER = 3'd3,
		ST_DIVZ  = 3'd4
	} status_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} md_req_t;

	typedef paddr_t pool_wrap_t [POOL_IN_DEPTH];

	function automatic pool_wrap_t build_pool_wrap();
		pool_wrap_t t;
		for (int i = 0; i < POOL_IN_DEPTH; i++) begin
			t[i] = PADDR_BITS'(i % POOL_DEPTH);
		end
		return t;
	endfunction

	localparam pool_wrap_t POOL_WRAP = build_pool_wrap();

	function automatic word_t from_field(input logic signed [FIELD_BITS-1:0] v);
		return word_t'(v);
	endfunction

	function automatic logic [FIELD_BITS-1:0] to_field(input word_t w);
		return FIELD_BITS'(w);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/stack_vm_integer_execute_top.sv -----
// top level: bytecode stack machine with operand stack and value pool in ram
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | input     | in_valid / in_ready   | action, pool_index, pool_value
//  out     | output    | out_valid / out_ready | status, value
//
// push, add, subtract, halt, store and pool write pass through transfer with stack and
// pool reads, execute, and commit of ram writes and result register.
// multiply (8 bits per cycle) and divide (one quotient bit per cycle) add a wait state
// while the shared iterative unit runs. reset clears the state, the stack count and
// the output valid flag; rams hold no reset value and get no clearing pass.
// commit waits while the output register still holds an untaken result; a new item
// is taken after commit while that result waits.
`default_nettype none

module stack_vm_integer_execute_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [svmie_pkg::ACTION_BITS-1:0]     action,
	input  logic [svmie_pkg::PIDX_IN_BITS-1:0]    pool_index,
	input  logic signed [svmie_pkg::FIELD_BITS-1:0] pool_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [svmie_pkg::STATUS_BITS-1:0]     status,
	output logic signed [svmie_pkg::FIELD_BITS-1:0] value
);
	import svmie_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_WAIT   = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t state_q;
	count_t count_q;
	word_t top_q;

	action_t act_s1;
	paddr_t pidx_s1;
	word_t pval_s1;

	status_t st_q;
	word_t val_q;
	count_t cnt_nx_q;
	word_t top_nx_q;
	logic swe_q;
	saddr_t swaddr_q;
	logic pwe_q;
	word_t pwdata_q;

	logic out_valid_q;
	status_t status_q;
	word_t value_q;

	logic accept;
	logic commit_fire;
	word_t stack_rd;
	word_t pool_rd;
	md_req_t md_req;
	logic md_done;
	word_t md_result;

	status_t ex_st;
	word_t ex_val;
	count_t ex_cnt;
	word_t ex_top;
	logic ex_swe;
	saddr_t ex_swaddr;
	logic ex_pwe;
	word_t ex_pwdata;
	logic ex_md;
	logic count_nz;
	logic count_two;
	logic count_full;
	count_t cnt_m1;
	saddr_t below_addr;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign commit_fire = (state_q == S_COMMIT) && (!out_valid_q || out_ready);

	assign count_nz = (count_q != '0);
	assign count_two = (count_q >= count_t'(2));
	assign count_full = (count_q == count_t'(STACK_DEPTH));
	assign cnt_m1 = count_q - count_t'(1);
	assign below_addr = SADDR_BITS'(count_q - count_t'(2));

	svmie_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (commit_fire && swe_q),
		.waddr(swaddr_q),
		.wdata(top_nx_q),
		.re   (accept),
		.raddr(below_addr),
		.rdata(stack_rd)
	);

	svmie_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(POOL_DEPTH)
	) u_pool_ram (
		.clk  (clk),
		.we   (commit_fire && pwe_q),
		.waddr(pidx_s1),
		.wdata(pwdata_q),
		.re   (accept),
		.raddr(POOL_WRAP[pool_index]),
		.rdata(pool_rd)
	);

	assign md_req.start = (state_q == S_EXEC) && ex_md;
	assign md_req.is_div = (act_s1 == ACT_DIV);

	svmie_muldiv u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.a     (stack_rd),
		.b     (top_q),
		.done  (md_done),
		.result(md_result)
	);

	always_comb begin
		ex_st = ST_OK;
		ex_val = '0;
		ex_cnt = count_q;
		ex_top = top_q;
		ex_swe = 1'b0;
		ex_swaddr = SADDR_BITS'(count_q);
		ex_pwe = 1'b0;
		ex_pwdata = top_q;
		ex_md = 1'b0;
		unique case (act_s1)
			ACT_HALT: begin
				if (!count_nz) begin
					ex_st = ST_UNDER;
				end else begin
					ex_st = ST_HALT;
					ex_val = top_q;
				end
				ex_cnt = '0;
			end
			ACT_PUSH: begin
				if (count_full) begin
					ex_st = ST_OVER;
				end else begin
					ex_swe = 1'b1;
					ex_top = pool_rd;
					ex_val = pool_rd;
					ex_cnt = count_q + count_t'(1);
				end
			end
			ACT_ADD, ACT_SUB: begin
				if (!count_two) begin
					ex_st = ST_UNDER;
				end else begin
					ex_swe = 1'b1;
					ex_swaddr = below_addr;
					ex_top = (act_s1 == ACT_ADD) ? (stack_rd + top_q) : (stack_rd - top_q);
					ex_val = ex_top;
					ex_cnt = cnt_m1;
				end
			end
			ACT_MUL, ACT_DIV: begin
				if (!count_two) begin
					ex_st = ST_UNDER;
				end else if (act_s1 == ACT_DIV && top_q == '0) begin
					ex_st = ST_DIVZ;
				end else begin
					ex_md = 1'b1;
					ex_swe = 1'b1;
					ex_swaddr = below_addr;
					ex_cnt = cnt_m1;
				end
			end
			ACT_STORE: begin
				if (!count_nz) begin
					ex_st = ST_UNDER;
				end else begin
					ex_pwe = 1'b1;
					ex_pwdata = top_q;
					ex_cnt = cnt_m1;
					ex_top = stack_rd;
					ex_val = (cnt_m1 != '0) ? stack_rd : '0;
				end
			end
			ACT_POOLWR: begin
				ex_pwe = 1'b1;
				ex_pwdata = pval_s1;
				ex_val = count_nz ? top_q : '0;
			end
		endcase
		if (ex_st == ST_OVER || ex_st == ST_UNDER || ex_st == ST_DIVZ) begin
			ex_cnt = '0;
			ex_val = '0;
			ex_swe = 1'b0;
			ex_pwe = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= ex_md ? S_WAIT : S_COMMIT;
				end
				S_WAIT: begin
					if (md_done) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (commit_fire) begin
						state_q <= S_IDLE;
						count_q <= cnt_nx_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1 <= action_t'(action);
			pidx_s1 <= POOL_WRAP[pool_index];
			pval_s1 <= from_field(pool_value);
		end
		if (state_q == S_EXEC) begin
			st_q <= ex_st;
			val_q <= ex_val;
			cnt_nx_q <= ex_cnt;
			top_nx_q <= ex_top;
			swe_q <= ex_swe;
			swaddr_q <= ex_swaddr;
			pwe_q <= ex_pwe;
			pwdata_q <= ex_pwdata;
		end
		if (state_q == S_WAIT && md_done) begin
			top_nx_q <= md_result;
			val_q <= md_result;
		end
		if (commit_fire) begin
			top_q <= top_nx_q;
			status_q <= st_q;
			value_q <= val_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign value = to_field(value_q);

endmodule

`default_nettype wire

// ----- rtl/core/svmie_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module svmie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/svmie_muldiv.sv -----
// iterative multiplier (one digit per cycle) and restoring signed divider (one bit per cycle)
`default_nettype none

module svmie_muldiv (
	input  logic               clk,
	input  logic               arst_n,
	input  svmie_pkg::md_req_t req,
	input  svmie_pkg::word_t   a,
	input  svmie_pkg::word_t   b,
	output logic               done,
	output svmie_pkg::word_t   result
);
	import svmie_pkg::*;

	logic busy_q;
	logic done_q;
	logic is_div_q;
	logic neg_q;
	step_t cnt_q;
	word_t acc_q;
	word_t mcand_q;
	word_t mplier_q;
	word_t rem_q;
	word_t quo_q;
	word_t dvs_q;

	logic [MUL_DIGIT-1:0] digit;
	word_t mul_part;
	logic [WORD_BITS:0] rem_sh;
	logic [WORD_BITS:0] diff;
	step_t last;
	word_t mag_a;
	word_t mag_b;

	assign digit = mplier_q[MUL_DIGIT-1:0];
	assign mul_part = mcand_q * word_t'(digit);
	assign rem_sh = {rem_q, quo_q[WORD_BITS-1]};
	assign diff = rem_sh - {1'b0, dvs_q};
	assign last = is_div_q ? STEP_BITS'(WORD_BITS - 1) : STEP_BITS'(MUL_STEPS - 1);
	assign mag_a = a[WORD_BITS-1] ? (word_t'(0) - a) : a;
	assign mag_b = b[WORD_BITS-1] ? (word_t'(0) - b) : b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			cnt_q <= '0;
			is_div_q <= req.is_div;
			neg_q <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
			acc_q <= '0;
			mcand_q <= a;
			mplier_q <= b;
			rem_q <= '0;
			quo_q <= mag_a;
			dvs_q <= mag_b;
		end else if (busy_q) begin
			cnt_q <= cnt_q + step_t'(1);
			if (is_div_q) begin
				if (!diff[WORD_BITS]) begin
					rem_q <= diff[WORD_BITS-1:0];
					quo_q <= {quo_q[WORD_BITS-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[WORD_BITS-1:0];
					quo_q <= {quo_q[WORD_BITS-2:0], 1'b0};
				end
			end else begin
				acc_q <= acc_q + mul_part;
				mcand_q <= mcand_q << MUL_DIGIT;
				mplier_q <= mplier_q >> MUL_DIGIT;
			end
		end
	end

	assign done = done_q;
	assign result = is_div_q ? (neg_q ? (word_t'(0) - quo_q) : quo_q) : acc_q;

endmodule

`default_nettype wire

// ----- rtl/core/svmie_checker.sv -----
// port-level checker for the stack machine top level, attached by bind
`default_nettype none

module svmie_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic [svmie_pkg::STATUS_BITS-1:0]       status,
	input logic signed [svmie_pkg::FIELD_BITS-1:0] value
);
	import svmie_pkg::*;

	logic in_xfer;
	logic err_status;

	assign in_xfer = in_valid && in_ready;
	assign err_status = (status == ST_OVER) || (status == ST_UNDER) || (status == ST_DIVZ);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value))
		else $error("result changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("second item taken while one is in flight");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && err_status |-> value == '0)
		else $error("error result carries nonzero value");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_xfer))
		else $error("result appeared right after an input transfer");

endmodule

bind stack_vm_integer_execute_top svmie_checker u_svmie_checker (.*);

`default_nettype wire
